### sv/jvs_pkg.sv
package jvs_pkg;

  // Default bracket depth limit; the hardware depth counter is 8 bits wide, so the limit is capped at 255.
  localparam int MAX_DEPTH_DEF = 255;

  // Skip phases.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_LEAD  = 3'd1,
    PH_CONT  = 3'd2,
    PH_STR   = 3'd3,
    PH_SCAL  = 3'd4,
    PH_TRAIL = 3'd5
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_BUSY   = 3'd0,
    ST_OK     = 3'd1,
    ST_BADESC = 3'd2,
    ST_BSOUT  = 3'd3,
    ST_EOI    = 3'd4,
    ST_DEPTH  = 3'd5
  } status_t;

  // Kind of value being skipped.
  typedef enum logic [1:0] {
    KIND_SCALAR = 2'd0,
    KIND_ARRAY  = 2'd1,
    KIND_OBJECT = 2'd2,
    KIND_STRING = 2'd3
  } kind_t;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_T       = 8'h74;

  // JSON whitespace.
  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  // Characters allowed after a backslash inside a string.
  function automatic logic esc_ok(input logic [7:0] c);
    return (c == CH_QUOTE) || (c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_B) ||
           (c == CH_F) || (c == CH_R) || (c == CH_N) || (c == CH_T);
  endfunction

endpackage

### sv/jvs_in_if.sv
interface jvs_in_if;
  logic       valid;
  logic       ready;
  logic       start_value;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, output start_value, output data_byte, output end_of_input,
                  input ready);
  modport sink (input valid, input start_value, input data_byte, input end_of_input,
                output ready);
endinterface

### sv/jvs_out_if.sv
interface jvs_out_if;
  logic       valid;
  logic       ready;
  logic       consumed;
  logic [2:0] status;
  logic [7:0] nesting_depth;

  modport source (output valid, output consumed, output status, output nesting_depth,
                  input ready);
  modport sink (input valid, input consumed, input status, input nesting_depth,
                output ready);
endinterface

### sv/json_value_skipper.sv
// Byte-serial JSON value skipper. Each request on in_ch carries one byte (or an end of
// input mark); start_value begins a new skip. Every request yields exactly one result
// on out_ch telling whether the byte belongs to the skipped value, the status (busy,
// done or an error) and the bracket depth after the byte. A request is first held in an
// input register; once the result register is empty or being drained, the combinational
// update of the phase, flags and depth counter loads the result register, which drives
// out_ch. A new request can be taken every cycle while the input does not stall; the input
// stalls only while a result waits on a stalled out_ch and the input register is also full.
// Bracket depth is limited to the smaller of MAX_DEPTH and 255.
module json_value_skipper #(
  parameter int MAX_DEPTH = jvs_pkg::MAX_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  jvs_in_if.sink         in_ch,
  jvs_out_if.source      out_ch
);
  import jvs_pkg::*;

  localparam logic [7:0] DEPTH_LIMIT = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

  // Input register.
  logic       s1_valid_r;
  logic       s1_start_r;
  logic [7:0] s1_byte_r;
  logic       s1_eoi_r;

  // Skip state.
  phase_t     phase_r, phase_nxt;
  kind_t      kind_r, kind_nxt;
  logic [7:0] depth_r, depth_nxt;
  logic       in_text_r, in_text_nxt;
  logic       esc_r, esc_nxt;

  // Result register.
  logic       out_valid_r;
  logic       out_consumed_r;
  status_t    out_status_r;
  logic [7:0] out_depth_r;

  logic       cons_nxt;
  status_t    st_nxt;
  logic       s1_adv;
  logic       in_take;

  // The input stage moves on when the result register is empty or being drained.
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.consumed      = out_consumed_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.nesting_depth = out_depth_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_take) begin
      s1_start_r <= in_ch.start_value;
      s1_byte_r  <= in_ch.data_byte;
      s1_eoi_r   <= in_ch.end_of_input;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      kind_r    <= KIND_SCALAR;
      depth_r   <= 8'd0;
      in_text_r <= 1'b0;
      esc_r     <= 1'b0;
    end else if (s1_adv) begin
      phase_r   <= phase_nxt;
      kind_r    <= kind_nxt;
      depth_r   <= depth_nxt;
      in_text_r <= in_text_nxt;
      esc_r     <= esc_nxt;
    end
  end

  // Next state and result for the byte in the input register.
  always_comb begin
    logic [7:0] c;
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    c           = s1_byte_r;
    phase_nxt   = s1_start_r ? PH_LEAD : phase_r;
    kind_nxt    = s1_start_r ? KIND_SCALAR : kind_r;
    depth_nxt   = s1_start_r ? 8'd0 : depth_r;
    in_text_nxt = s1_start_r ? 1'b0 : in_text_r;
    esc_nxt     = s1_start_r ? 1'b0 : esc_r;
    cons_nxt    = 1'b0;
    st_nxt      = ST_BUSY;
    open_ch     = (kind_nxt == KIND_ARRAY) ? CH_LBRACK : CH_LBRACE;
    close_ch    = (kind_nxt == KIND_ARRAY) ? CH_RBRACK : CH_RBRACE;

    if (phase_nxt != PH_IDLE && s1_eoi_r) begin
      st_nxt    = (phase_nxt == PH_TRAIL) ? ST_OK : ST_EOI;
      phase_nxt = PH_IDLE;
    end else begin
      case (phase_nxt)
        PH_IDLE: begin
          phase_nxt = PH_IDLE;
        end
        PH_LEAD: begin
          if (is_ws(c)) begin
            cons_nxt = 1'b1;
          end else if (c == CH_LBRACK || c == CH_LBRACE) begin
            cons_nxt  = 1'b1;
            kind_nxt  = (c == CH_LBRACK) ? KIND_ARRAY : KIND_OBJECT;
            depth_nxt = 8'd1;
            phase_nxt = PH_CONT;
          end else if (c == CH_QUOTE) begin
            cons_nxt    = 1'b1;
            kind_nxt    = KIND_STRING;
            in_text_nxt = 1'b1;
            phase_nxt   = PH_STR;
          end else if (c == CH_COMMA) begin
            st_nxt    = ST_OK;
            phase_nxt = PH_IDLE;
          end else begin
            cons_nxt  = 1'b1;
            kind_nxt  = KIND_SCALAR;
            phase_nxt = PH_SCAL;
          end
        end
        PH_SCAL: begin
          if (is_ws(c) || c == CH_COMMA) begin
            st_nxt    = ST_OK;
            phase_nxt = PH_IDLE;
          end else begin
            cons_nxt = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (is_ws(c)) begin
            cons_nxt = 1'b1;
          end else begin
            cons_nxt  = (c == CH_COMMA);
            st_nxt    = ST_OK;
            phase_nxt = PH_IDLE;
          end
        end
        PH_CONT, PH_STR: begin
          cons_nxt = 1'b1;
          if (esc_nxt) begin
            if (esc_ok(c)) begin
              esc_nxt = 1'b0;
            end else begin
              st_nxt    = ST_BADESC;
              phase_nxt = PH_IDLE;
            end
          end else if (c == CH_BSLASH) begin
            if (!in_text_nxt) begin
              st_nxt    = ST_BSOUT;
              phase_nxt = PH_IDLE;
            end else begin
              esc_nxt = 1'b1;
            end
          end else if (c == CH_QUOTE) begin
            in_text_nxt = !in_text_nxt;
            if (phase_nxt == PH_STR) begin
              in_text_nxt = 1'b0;
              phase_nxt   = PH_TRAIL;
            end
          end else if (phase_nxt == PH_CONT && !in_text_nxt) begin
            if (c == close_ch) begin
              depth_nxt = depth_nxt - 8'd1;
              if (depth_nxt == 8'd0) begin
                phase_nxt = PH_TRAIL;
              end
            end else if (c == open_ch) begin
              if (depth_nxt >= DEPTH_LIMIT) begin
                st_nxt    = ST_DEPTH;
                phase_nxt = PH_IDLE;
              end else begin
                depth_nxt = depth_nxt + 8'd1;
              end
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Result register; it holds while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_consumed_r <= cons_nxt;
      out_status_r   <= st_nxt;
      out_depth_r    <= depth_nxt;
    end
  end

`ifndef SYNTHESIS
  // An escape can only be pending inside a string.
  a_esc_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> in_text_r)
    else $error("escape pending outside a string");

  // A string value never carries bracket depth.
  a_str_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STR) |-> (depth_r == 8'd0 && in_text_r))
    else $error("string phase with depth or without text flag");

  // Inside a container the depth stays within its limit.
  a_cont_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CONT) |-> (depth_r != 8'd0 && depth_r <= DEPTH_LIMIT))
    else $error("container depth out of range");

  // Any final status returns the skipper to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && st_nxt != ST_BUSY) |=> (phase_r == PH_IDLE))
    else $error("request finished but phase not idle");

  // Input backpressure only comes from a waiting result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && s1_valid_r))
    else $error("input stalled without a pending result");
`endif

endmodule

### dv/json_value_skipper_tb.sv
`timescale 1ns / 1ps

module json_value_skipper_tb;
  import jvs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int STIM_ITEMS  = 2000;
  localparam int DEPTH_CAP   = (MAX_DEPTH_DEF > 255) ? 255 : MAX_DEPTH_DEF;

  typedef struct packed {
    logic       start;
    logic [7:0] data;
    logic       eoi;
  } skip_req_t;

  typedef struct packed {
    logic       consumed;
    status_t    status;
    logic [7:0] depth;
  } skip_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  jvs_in_if  in_ch ();
  jvs_out_if out_ch ();

  json_value_skipper dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Byte requests waiting to be sent, and the results they are predicted to give.
  skip_req_t stream_q[$];
  skip_res_t verdict_q[$];

  // Shadow state of the skipper.
  phase_t     sk_phase  = PH_IDLE;
  kind_t      sk_kind   = KIND_SCALAR;
  logic [7:0] sk_depth  = 8'd0;
  logic       sk_in_str = 1'b0;
  logic       sk_esc    = 1'b0;

  int  bad_count = 0;
  int  cycle_count = 0;
  int  send_gap = 0;
  int  send_calm = 0;
  int  recv_stall = 0;
  int  recv_calm = 0;
  bit  fresh = 1'b0;

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic bit escape_char(input logic [7:0] c);
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_R, CH_N, CH_T: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] pick_ws();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  // Advance the shadow state by one byte request and give the expected result.
  task automatic predict_skip(input skip_req_t rq, output skip_res_t rs);
    logic [7:0] c;
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    c = rq.data;
    rs.consumed = 1'b0;
    rs.status = ST_BUSY;
    if (rq.start) begin
      sk_phase = PH_LEAD;
      sk_kind = KIND_SCALAR;
      sk_depth = 8'd0;
      sk_in_str = 1'b0;
      sk_esc = 1'b0;
    end
    if (sk_phase != PH_IDLE) begin
      if (rq.eoi) begin
        rs.status = (sk_phase == PH_TRAIL) ? ST_OK : ST_EOI;
        sk_phase = PH_IDLE;
      end else begin
        case (sk_phase)
          PH_LEAD: begin
            if (is_blank(c)) begin
              rs.consumed = 1'b1;
            end else if (c == CH_LBRACK || c == CH_LBRACE) begin
              rs.consumed = 1'b1;
              sk_kind = (c == CH_LBRACK) ? KIND_ARRAY : KIND_OBJECT;
              sk_depth = 8'd1;
              sk_phase = PH_CONT;
            end else if (c == CH_QUOTE) begin
              rs.consumed = 1'b1;
              sk_kind = KIND_STRING;
              sk_in_str = 1'b1;
              sk_phase = PH_STR;
            end else if (c == CH_COMMA) begin
              rs.status = ST_OK;
              sk_phase = PH_IDLE;
            end else begin
              rs.consumed = 1'b1;
              sk_kind = KIND_SCALAR;
              sk_phase = PH_SCAL;
            end
          end
          PH_SCAL: begin
            if (is_blank(c) || c == CH_COMMA) begin
              rs.status = ST_OK;
              sk_phase = PH_IDLE;
            end else begin
              rs.consumed = 1'b1;
            end
          end
          PH_TRAIL: begin
            if (is_blank(c)) begin
              rs.consumed = 1'b1;
            end else begin
              rs.consumed = (c == CH_COMMA);
              rs.status = ST_OK;
              sk_phase = PH_IDLE;
            end
          end
          PH_CONT, PH_STR: begin
            rs.consumed = 1'b1;
            if (sk_esc) begin
              if (escape_char(c)) begin
                sk_esc = 1'b0;
              end else begin
                rs.status = ST_BADESC;
                sk_phase = PH_IDLE;
              end
            end else if (c == CH_BSLASH) begin
              if (!sk_in_str) begin
                rs.status = ST_BSOUT;
                sk_phase = PH_IDLE;
              end else begin
                sk_esc = 1'b1;
              end
            end else if (c == CH_QUOTE) begin
              sk_in_str = ~sk_in_str;
              if (sk_phase == PH_STR) begin
                sk_in_str = 1'b0;
                sk_phase = PH_TRAIL;
              end
            end else if (sk_phase == PH_CONT && !sk_in_str) begin
              // Only the bracket kind that opened the value is counted.
              open_ch = (sk_kind == KIND_ARRAY) ? CH_LBRACK : CH_LBRACE;
              close_ch = (sk_kind == KIND_ARRAY) ? CH_RBRACK : CH_RBRACE;
              if (c == close_ch) begin
                sk_depth = sk_depth - 8'd1;
                if (sk_depth == 8'd0) sk_phase = PH_TRAIL;
              end else if (c == open_ch) begin
                if (sk_depth >= DEPTH_CAP) begin
                  rs.status = ST_DEPTH;
                  sk_phase = PH_IDLE;
                end else begin
                  sk_depth = sk_depth + 8'd1;
                end
              end
            end
          end
          default: sk_phase = PH_IDLE;
        endcase
      end
    end
    rs.depth = sk_depth;
  endtask

  task automatic send(input logic s, input logic [7:0] d, input logic e);
    skip_req_t rq;
    rq = '{s, d, e};
    stream_q.insert(stream_q.size(), rq);
  endtask

  // Byte of the value being built; the first one of a value carries the start flag.
  task automatic put(input logic [7:0] d);
    send(fresh, d, 1'b0);
    fresh = 1'b0;
  endtask

  task automatic put_end();
    send(fresh, 8'($urandom_range(255)), 1'b1);
    fresh = 1'b0;
  endtask

  task automatic put_ws(input int n);
    repeat (n) put(pick_ws());
  endtask

  // A scalar token; a loose one may hold any byte that does not end it.
  task automatic put_scalar(input bit loose);
    logic [7:0] c;
    put(($urandom_range(1) == 1) ? 8'("a") + 8'($urandom_range(25))
                                 : 8'("0") + 8'($urandom_range(9)));
    repeat ($urandom_range(5)) begin
      if (loose) begin
        do c = 8'($urandom_range(255)); while (is_blank(c) || c == CH_COMMA);
      end else begin
        c = 8'("a") + 8'($urandom_range(25));
      end
      put(c);
    end
  endtask

  // A quoted string with escapes; now and then it breaks off with an error.
  task automatic put_string(output bit broke);
    logic [7:0] c;
    int r;
    broke = 1'b0;
    put(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      r = $urandom_range(99);
      if (r < 65) begin
        do c = 8'($urandom_range(255)); while (c == CH_QUOTE || c == CH_BSLASH);
        put(c);
      end else if (r < 94) begin
        put(CH_BSLASH);
        do c = 8'($urandom_range(255)); while (!escape_char(c));
        put(c);
      end else if (r < 97) begin
        put(CH_BSLASH);
        do c = 8'($urandom_range(255)); while (escape_char(c));
        put(c);
        broke = 1'b1;
        return;
      end else begin
        put_end();
        broke = 1'b1;
        return;
      end
    end
    put(CH_QUOTE);
  endtask

  // Brackets nested to the counter limit, then either one more or all closed again.
  task automatic put_deep(input bit spill);
    logic [7:0] open_ch;
    logic [7:0] close_ch;
    open_ch = ($urandom_range(1) == 1) ? CH_LBRACK : CH_LBRACE;
    close_ch = (open_ch == CH_LBRACK) ? CH_RBRACK : CH_RBRACE;
    fresh = 1'b1;
    repeat (DEPTH_CAP) put(open_ch);
    if (spill) begin
      put(open_ch);
    end else begin
      repeat (DEPTH_CAP) put(close_ch);
      put(CH_COMMA);
    end
  endtask

  // Stimulus, reset and end of run.
  initial begin : stim_proc
    int pick;
    int r;
    int n;
    int k;
    int base;
    bit cut;
    logic [7:0] closers[$];

    // Nothing active yet: the byte is ignored.
    send(1'b0, 8'hFF, 1'b0);
    // A comma right away is an empty scalar.
    send(1'b1, CH_COMMA, 1'b0);
    // Leading whitespace, then a scalar that swallows a bracket and ends at a comma.
    send(1'b1, CH_TAB, 1'b0);
    send(1'b0, CH_CR, 1'b0);
    send(1'b0, CH_LF, 1'b0);
    send(1'b0, "7", 1'b0);
    send(1'b0, CH_LBRACK, 1'b0);
    send(1'b0, CH_COMMA, 1'b0);
    // Bad escape inside a string.
    send(1'b1, CH_QUOTE, 1'b0);
    send(1'b0, CH_BSLASH, 1'b0);
    send(1'b0, "q", 1'b0);
    // Backslash outside a string inside an array.
    send(1'b1, CH_LBRACK, 1'b0);
    send(1'b0, CH_BSLASH, 1'b0);
    // Object with a brace inside a string, closed, then space and a comma.
    send(1'b1, CH_LBRACE, 1'b0);
    send(1'b0, CH_QUOTE, 1'b0);
    send(1'b0, CH_RBRACE, 1'b0);
    send(1'b0, CH_QUOTE, 1'b0);
    send(1'b0, CH_RBRACE, 1'b0);
    send(1'b0, CH_SPACE, 1'b0);
    send(1'b0, CH_COMMA, 1'b0);
    // A new start drops an open string; end of input cuts the scalar short.
    send(1'b1, CH_QUOTE, 1'b0);
    send(1'b1, "x", 1'b0);
    send(1'b0, 8'h00, 1'b1);
    // End of input after a closed string is a normal finish.
    send(1'b1, CH_QUOTE, 1'b0);
    send(1'b0, CH_QUOTE, 1'b0);
    send(1'b0, 8'hAA, 1'b1);
    // Empty array followed by a byte that is left for the caller.
    send(1'b1, CH_LBRACK, 1'b0);
    send(1'b0, CH_RBRACK, 1'b0);
    send(1'b0, "x", 1'b0);

    // Nesting overflow at the counter limit.
    put_deep(1'b1);

    base = stream_q.size();
    while (stream_q.size() < base + STIM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick == 0) begin
        put_deep($urandom_range(1) == 1);
      end else if (pick < 13) begin
        // Raw noise: random bytes, starts and ends of input.
        repeat ($urandom_range(8, 1))
          send($urandom_range(7) == 0, 8'($urandom_range(255)), $urandom_range(9) == 0);
      end else begin
        fresh = 1'b1;
        cut = 1'b0;
        put_ws($urandom_range(2));
        pick = $urandom_range(99);
        if (pick < 5) begin
          put(CH_COMMA);
        end else if (pick < 25) begin
          put_string(cut);
        end else if (pick < 75) begin
          // Container with nested values of both bracket kinds.
          closers = {};
          if ($urandom_range(1) == 1) begin
            put(CH_LBRACK);
            closers.insert(closers.size(), CH_RBRACK);
          end else begin
            put(CH_LBRACE);
            closers.insert(closers.size(), CH_RBRACE);
          end
          n = $urandom_range(14, 1);
          for (k = 0; k < n && !cut; k++) begin
            r = $urandom_range(99);
            if (r < 18 && closers.size() < 8) begin
              if ($urandom_range(1) == 1) begin
                put(CH_LBRACK);
                closers.insert(closers.size(), CH_RBRACK);
              end else begin
                put(CH_LBRACE);
                closers.insert(closers.size(), CH_RBRACE);
              end
            end else if (r < 36 && closers.size() > 1) begin
              put(closers.pop_back());
            end else if (r < 58) begin
              put_string(cut);
            end else if (r < 70) begin
              put_scalar(1'b0);
            end else if (r < 80) begin
              put(pick_ws());
            end else if (r < 89) begin
              put(CH_COMMA);
            end else if (r < 97) begin
              put(":");
            end else begin
              if ($urandom_range(1) == 1) put(CH_BSLASH);
              else put_end();
              cut = 1'b1;
            end
          end
          while (!cut && closers.size() > 0) put(closers.pop_back());
        end else begin
          put_scalar(1'b1);
        end

        // What follows the value.
        if (!cut) begin
          pick = $urandom_range(99);
          if (pick < 40) begin
            put_ws($urandom_range(3));
            put(CH_COMMA);
            put(8'($urandom_range(255)));
          end else if (pick < 65) begin
            put_ws($urandom_range(2));
            put(($urandom_range(1) == 1) ? CH_RBRACK : 8'("x"));
          end else if (pick < 82) begin
            put_ws($urandom_range(2));
            put_end();
          end
        end
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (stream_q.size() != 0 || in_ch.valid || verdict_q.size() != 0);
    repeat (10) @(negedge clk);

    if (bad_count == 0) begin
      $display("PASS json_value_skipper");
    end else begin
      $display("FAIL json_value_skipper");
    end
    $finish;
  end

  // Driver: predict each accepted request and present the next one after a random gap that may be zero.
  always @(posedge clk) begin : drive_proc
    skip_req_t cur;
    skip_req_t nxt;
    skip_res_t res;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.start_value <= 1'b0;
      in_ch.data_byte <= 8'h00;
      in_ch.end_of_input <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cur = '{in_ch.start_value, in_ch.data_byte, in_ch.end_of_input};
        predict_skip(cur, res);
        verdict_q.insert(verdict_q.size(), res);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (stream_q.size() > 0) begin
          nxt = stream_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.start_value <= nxt.start;
          in_ch.data_byte <= nxt.data;
          in_ch.end_of_input <= nxt.eoi;
          if (send_calm > 0) begin
            send_calm <= send_calm - 1;
            send_gap <= 0;
          end else begin
            send_gap <= draw_gap();
            if ($urandom_range(39) == 0) send_calm <= $urandom_range(120, 30);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction.
  always @(posedge clk) begin : watch_proc
    skip_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          bad_count++;
          $display("%0t: unexpected result consumed=%0d status=%0d depth=%0d", $time,
                   out_ch.consumed, out_ch.status, out_ch.nesting_depth);
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.consumed !== want.consumed) begin
            bad_count++;
            $display("%0t: consumed expected %0d, got %0d", $time, want.consumed,
                     out_ch.consumed);
          end
          if (out_ch.status !== want.status) begin
            bad_count++;
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     out_ch.status);
          end
          if (out_ch.nesting_depth !== want.depth) begin
            bad_count++;
            $display("%0t: nesting_depth expected %0d, got %0d", $time, want.depth,
                     out_ch.nesting_depth);
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall <= recv_stall - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm <= recv_calm - 1;
          recv_stall <= 0;
        end else begin
          recv_stall <= draw_gap();
          if ($urandom_range(39) == 0) recv_calm <= $urandom_range(120, 30);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL json_value_skipper");
      $finish;
    end
  end

endmodule
